@@ rtl/core/rgb_lightness_tint_defines.svh @@
// assertion macros for the lightness tint block
// used by the top level only, expects clk and arst_n in scope
`ifndef RGB_LIGHTNESS_TINT_DEFINES_SVH
`define RGB_LIGHTNESS_TINT_DEFINES_SVH

// same-cycle implication
`define RLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rlt_pkg.sv @@
// shared types and constants of the lightness tint block
// no dependencies
`default_nettype none

package rlt_pkg;

	localparam logic signed [16:0] TINT_MAX = 17'sd32768;
	localparam logic signed [16:0] TINT_MIN = -17'sd32768;
	localparam int unsigned TINT_RND = 16384;
	localparam int unsigned L_DEN = 510;
	localparam int unsigned L_DIV = 255;
	localparam int unsigned L_RND = 127;
	localparam int unsigned L_RCP = 131587;
	localparam int unsigned L_RSH = 25;
	localparam int unsigned BYTE_MAX = 255;

	typedef struct packed {
		logic [23:0]        color;
		logic signed [16:0] tint;
		logic               zero;
	} side_t;

endpackage

`default_nettype wire

@@ rtl/core/rlt_in_if.sv @@
// input channel: color and tint beat
// no dependencies
`default_nettype none

interface rlt_in_if;
	logic               valid;
	logic               ready;
	logic [23:0]        color_in;
	logic signed [16:0] tint_amount;

	modport source(output valid, output color_in, output tint_amount, input ready);
	modport sink(input valid, input color_in, input tint_amount, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rlt_out_if.sv @@
// output channel: tinted color beat
// no dependencies
`default_nettype none

interface rlt_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] color_out;

	modport source(output valid, output color_out, input ready);
	modport sink(input valid, input color_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgb_lightness_tint.sv @@
// path: capture, operand, divider, tint and rgb stages from input beat to output beat
// throughput: one beat per cycle while the output is not stalled, set by the one-bit-per-stage dividers
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset clears only the valid bits, payload registers are not reset
// depends on rlt_pkg, rlt_in_if, rlt_out_if, rlt_div, rlt_tint, rlt_rgb
`default_nettype none
`include "rgb_lightness_tint_defines.svh"

module rgb_lightness_tint import rlt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rlt_in_if.sink    color_ch,
	rlt_out_if.source result_ch
);
	localparam int F   = FRAC_BITS;
	localparam int W   = F + 1;
	localparam int QW  = F + 1;
	localparam int SD  = QW + 5;
	localparam int L   = SD + 2;
	localparam int HNW = F + 12;
	localparam int HDW = 11;
	localparam int SNW = F + 10;
	localparam int SDW = 9;
	localparam int LA  = (1 << (F - 1)) / L_DIV;
	localparam int LB  = (1 << (F - 1)) % L_DIV;

	logic         en;
	logic [L-1:0] vld_q;

	assign en = !vld_q[L-1] || result_ch.ready;
	assign color_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], color_ch.valid};
		end
	end

	// stage 1: capture and saturate tint
	side_t              side_s1, side_s2;
	logic signed [16:0] ts;

	always_comb begin
		ts = color_ch.tint_amount;
		if (ts > TINT_MAX) ts = TINT_MAX;
		else if (ts < TINT_MIN) ts = TINT_MIN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.color <= color_ch.color_in;
			side_s1.tint  <= ts;
			side_s1.zero  <= ts == 17'sd0;
		end
	end

	// stage 2: max, min, hue sector and divider operands
	logic [7:0]     r, g, b, mx, mn, d, den;
	logic [8:0]     sum;
	logic [11:0]    x;
	logic [HNW-1:0] hn_s2;
	logic [HDW-1:0] hd_s2;
	logic [SNW-1:0] sn_s2;
	logic [SDW-1:0] sd_s2;
	logic [W-1:0]   la_s2;
	logic [16:0]    lz_s2;

	always_comb begin
		r   = side_s1.color[23:16];
		g   = side_s1.color[15:8];
		b   = side_s1.color[7:0];
		mx  = (r > g) ? r : g;
		mn  = (r < g) ? r : g;
		if (b > mx) mx = b;
		if (b < mn) mn = b;
		d   = mx - mn;
		sum = 9'(mx) + 9'(mn);
		den = (sum <= 9'd255) ? sum[7:0] : 8'(9'(L_DEN) - sum);
		if (mx == r)
			x = 12'(g) - 12'(b) + ((b > g) ? 12'(d) * 12'd6 : 12'd0);
		else if (mx == g)
			x = 12'(d) * 12'd2 + 12'(b) - 12'(r);
		else
			x = 12'(d) * 12'd4 + 12'(r) - 12'(g);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			la_s2   <= W'(32'(sum) * 32'(LA));
			lz_s2   <= 17'(32'(sum) * 32'(LB) + 32'(L_RND));
			if (d == 8'd0) begin
				hn_s2 <= '0;
				hd_s2 <= HDW'(1);
				sn_s2 <= '0;
				sd_s2 <= SDW'(1);
			end else begin
				hn_s2 <= (HNW'(x) << F) + HNW'(d) * HNW'(3);
				hd_s2 <= HDW'(d) * HDW'(6);
				sn_s2 <= (SNW'(d) << (F + 1)) + SNW'(den);
				sd_s2 <= {den, 1'b0};
			end
		end
	end

	// side data delay line
	side_t side_q [SD];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			for (int i = 1; i < SD; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// lightness: divide by 510 as reciprocal multiply, then delay to the dividers
	logic [34:0]  lp;
	logic [W-1:0] l_q [QW];

	assign lp = 35'(lz_s2) * 35'(L_RCP);

	always_ff @(posedge clk) begin
		if (en) begin
			l_q[0] <= la_s2 + W'(lp >> L_RSH);
			for (int i = 1; i < QW; i++) begin
				l_q[i] <= l_q[i-1];
			end
		end
	end

	// dividers: hue, saturation
	logic [QW-1:0] h_d, s_d;

	rlt_div #(.NW(HNW), .DW(HDW), .QW(QW)) u_div_h (
		.clk(clk), .en(en), .num(hn_s2), .den(hd_s2), .quo(h_d)
	);

	rlt_div #(.NW(SNW), .DW(SDW), .QW(QW)) u_div_s (
		.clk(clk), .en(en), .num(sn_s2), .den(sd_s2), .quo(s_d)
	);

	logic [W-1:0] p_t, q_t, fr_t, fg_t, fb_t;

	rlt_tint #(.F(F)) u_tint (
		.clk(clk), .en(en), .l(l_q[QW-1]), .s(s_d), .h(h_d),
		.tint(side_q[QW-1].tint),
		.p(p_t), .q(q_t), .fr(fr_t), .fg(fg_t), .fb(fb_t)
	);

	logic [23:0] rgb;

	rlt_rgb #(.F(F)) u_rgb (
		.clk(clk), .en(en), .p(p_t), .q(q_t),
		.fr(fr_t), .fg(fg_t), .fb(fb_t), .rgb(rgb)
	);

	assign result_ch.valid     = vld_q[L-1];
	assign result_ch.color_out = side_q[SD-1].zero ? side_q[SD-1].color : rgb;

	`RLT_ASSERT_NOW(a_empty_accepts, !result_ch.valid, color_ch.ready, "input blocked while output empty")
	`RLT_ASSERT_NEXT(a_stall_freezes, result_ch.valid && !result_ch.ready, $stable(vld_q), "pipeline moved during stall")
	`RLT_ASSERT_NOW(a_p_below_q, vld_q[QW+4], p_t <= q_t, "p above q")

endmodule

`default_nettype wire

@@ rtl/core/rlt_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// no dependencies
`default_nettype none

module rlt_div #(
	parameter int NW = 28,
	parameter int DW = 11,
	parameter int QW = 17
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);
	localparam int WW = (NW > DW + QW) ? NW : DW + QW;

	logic [WW-1:0] rem_q [QW-1];
	logic [DW-1:0] den_q [QW-1];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [WW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] quo_i;
		logic [WW-1:0] dsh;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_i = WW'(num);
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign quo_i = quo_q[k-1];
		end

		assign dsh  = WW'(den_i) << (QW - 1 - k);
		assign take = rem_i >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= take ? (quo_i | (QW'(1) << (QW - 1 - k))) : quo_i;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? rem_i - dsh : rem_i;
					den_q[k] <= den_i;
				end
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

`default_nettype wire

@@ rtl/core/rlt_tint.sv @@
// lightness tint and hls to channel level setup, three stages
// depends on rlt_pkg
`default_nettype none

module rlt_tint import rlt_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [F:0]         l,
	input  wire logic [F:0]         s,
	input  wire logic [F:0]         h,
	input  wire logic signed [16:0] tint,
	output logic      [F:0]         p,
	output logic      [F:0]         q,
	output logic      [F:0]         fr,
	output logic      [F:0]         fg,
	output logic      [F:0]         fb
);
	localparam int W  = F + 1;
	localparam int UW = F + 3;
	localparam logic [W-1:0]  ONE   = W'(1) << F;
	localparam logic [W-1:0]  HALF  = W'(1) << (F - 1);
	localparam logic [UW-1:0] U_ONE = UW'(1) << F;
	localparam logic [UW-1:0] U2    = UW'(2 * (64'd1 << F));
	localparam logic [UW-1:0] U3    = UW'(3 * (64'd1 << F));
	localparam logic [UW-1:0] U4    = UW'(4 * (64'd1 << F));
	localparam logic [UW-1:0] U6    = UW'(6 * (64'd1 << F));

	function automatic logic [W-1:0] ramp(input logic [UW-1:0] u);
		logic [UW-1:0] d;
		d = U4 - u;
		if (u < U_ONE)
			return W'(u);
		else if (u < U3)
			return ONE;
		else if (u < U4)
			return W'(d);
		else
			return '0;
	endfunction

	// stage 1: new lightness
	logic              neg;
	logic [W-1:0]      m;
	logic signed [16:0] kk;
	logic [15:0]       k;
	logic [W+15:0]     prod, rnd;
	logic [W:0]        res, lsum;
	logic [F-1:0]      hw;
	logic [W-1:0]      ln_s1, s_s1;
	logic [F-1:0]      h_s1;

	always_comb begin
		neg  = tint[16];
		m    = neg ? l : ONE - l;
		kk   = TINT_MAX + tint;
		k    = neg ? kk[15:0] : tint[15:0];
		prod = (W+16)'(m) * (W+16)'(k);
		rnd  = prod + (W+16)'(TINT_RND);
		res  = rnd[W+15:15];
		lsum = neg ? res : {1'b0, l} + res;
		hw   = (h >= ONE) ? F'(h - ONE) : h[F-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s1 <= (lsum > {1'b0, ONE}) ? ONE : lsum[W-1:0];
			s_s1  <= s;
			h_s1  <= hw;
		end
	end

	// stage 2: saturation times lightness
	logic [2*W-1:0] sp;
	logic [W-1:0]   sl_s2, ln_s2, s_s2;
	logic [F-1:0]   h_s2;

	assign sp = (2*W)'(s_s1) * (2*W)'(ln_s1) + (2*W)'(HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			sl_s2 <= W'(sp[2*W-1:F]);
			ln_s2 <= ln_s1;
			s_s2  <= s_s1;
			h_s2  <= h_s1;
		end
	end

	// stage 3: q, p and per-channel ramp factor
	logic [W:0]    qw, twol, pw;
	logic [W-1:0]  qc, pc;
	logic [UW-1:0] h6, ur, ub;

	always_comb begin
		qw   = (ln_s2 < HALF) ? {1'b0, ln_s2} + {1'b0, sl_s2}
		                      : {1'b0, ln_s2} + {1'b0, s_s2} - {1'b0, sl_s2};
		qc   = (qw > {1'b0, ONE}) ? ONE : qw[W-1:0];
		twol = {ln_s2, 1'b0};
		pw   = (twol > {1'b0, qc}) ? twol - {1'b0, qc} : '0;
		pc   = (pw > {1'b0, ONE}) ? ONE : pw[W-1:0];
		if (pc > qc) pc = qc;
		h6   = UW'(h_s2) * UW'(6);
		ur   = h6 + U2;
		if (ur >= U6) ur = ur - U6;
		ub   = (h6 >= U2) ? h6 - U2 : h6 + U4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q  <= qc;
			p  <= pc;
			fr <= ramp(ur);
			fg <= ramp(h6);
			fb <= ramp(ub);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rlt_rgb.sv @@
// channel levels and 8-bit rounding, two stages
// depends on rlt_pkg
`default_nettype none

module rlt_rgb import rlt_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [F:0]  p,
	input  wire logic [F:0]  q,
	input  wire logic [F:0]  fr,
	input  wire logic [F:0]  fg,
	input  wire logic [F:0]  fb,
	output logic      [23:0] rgb
);
	localparam int W = F + 1;
	localparam logic [2*W-1:0] HALF2 = (2*W)'(1) << (F - 1);
	localparam logic [W+7:0]   HALF8 = (W+8)'(1) << (F - 1);

	logic [W-1:0] f [3];
	logic [W-1:0] c_s1 [3];
	logic [7:0]   b_c [3];

	assign f[0] = fr;
	assign f[1] = fg;
	assign f[2] = fb;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= p + W'((((2*W)'(q - p) * (2*W)'(f[i])) + HALF2) >> F);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [W+7:0] cb;
			logic [8:0]   v;
			cb = (W+8)'(c_s1[i]) * (W+8)'(BYTE_MAX) + HALF8;
			v  = 9'(cb >> F);
			b_c[i] = (v > 9'(BYTE_MAX)) ? 8'(BYTE_MAX) : v[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb <= {b_c[0], b_c[1], b_c[2]};
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_rgb_lightness_tint.sv @@
// testbench of the lightness tint block: directed table then random beats,
// each result checked against a fixed-point hls tint predictor
// depends on rlt_pkg, rlt_in_if, rlt_out_if and rgb_lightness_tint
`timescale 1ns / 1ps

module tb_rgb_lightness_tint import rlt_pkg::*;;

	localparam int FB = 16;
	localparam longint ONE = 64'd1 << FB;
	localparam longint HALF = 64'd1 << (FB - 1);
	localparam int LATENCY = FB + 8;

	typedef struct {
		logic [23:0]        color;
		logic signed [16:0] tint;
		logic               known;
		logic [23:0]        color_exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rlt_in_if color_ch();
	rlt_out_if result_ch();

	logic [23:0] tinted_q[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_cycles = 0;

	rgb_lightness_tint #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .color_ch(color_ch), .result_ch(result_ch)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned lvl(longint unsigned u, longint unsigned p,
			longint unsigned q);
		longint unsigned span;
		span = q - p;
		if (u < ONE) return p + ((span * u + HALF) >> FB);
		if (u < 3 * ONE) return q;
		if (u < 4 * ONE) return p + ((span * (4 * ONE - u) + HALF) >> FB);
		return p;
	endfunction

	function automatic logic [7:0] to_byte(longint unsigned c);
		longint unsigned v;
		v = (c * 255 + HALF) >> FB;
		return (v > 255) ? 8'hff : v[7:0];
	endfunction

	function automatic logic [23:0] tint_color(logic [23:0] color, logic signed [16:0] tint_raw);
		longint t, r, g, b, mx, mn, d, x;
		longint unsigned sum, h, s, l, den, k, sl, q, p, h6, turn;
		t = tint_raw;
		if (t > 32768) t = 32768;
		if (t < -32768) t = -32768;
		if (t == 0) return color;
		r = color[23:16]; g = color[15:8]; b = color[7:0];
		mx = (r > g) ? r : g;
		mn = (r < g) ? r : g;
		if (b > mx) mx = b;
		if (b < mn) mn = b;
		d = mx - mn;
		sum = mx + mn;
		h = 0; s = 0;
		l = (2 * sum * ONE + 510) / 1020;
		if (d > 0) begin
			if (mx == r) x = (g - b) + ((b > g) ? 6 * d : 0);
			else if (mx == g) x = 2 * d + b - r;
			else x = 4 * d + r - g;
			h = (2 * x * ONE + 6 * d) / (12 * d);
			if (h >= ONE) h -= ONE;
			den = (sum <= 255) ? sum : 510 - sum;
			s = (2 * d * ONE + den) / (2 * den);
		end
		if (t < 0) begin
			k = 32768 + t;
			l = (l * k + 16384) >> 15;
		end else begin
			k = t;
			l = l + (((ONE - l) * k + 16384) >> 15);
		end
		if (l > ONE) l = ONE;
		sl = (s * l + HALF) >> FB;
		q = (l < HALF) ? l + sl : l + s - sl;
		if (q > ONE) q = ONE;
		p = (2 * l > q) ? 2 * l - q : 0;
		if (p > ONE) p = ONE;
		if (p > q) p = q;
		turn = 6 * ONE;
		h6 = 6 * h;
		return {to_byte(lvl((h6 + 2 * ONE) % turn, p, q)), to_byte(lvl(h6 % turn, p, q)),
			to_byte(lvl((h6 + turn - 2 * ONE) % turn, p, q))};
	endfunction

	// result side: random stall, long hold-off when asked
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			beats_out <= beats_out + 1;
			if (tinted_q.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected beat, actual %06h", $time, result_ch.color_out);
			end else begin
				if (tinted_q[0] !== result_ch.color_out) begin
					errors <= errors + 1;
					$display("%0t: color_out mismatch, expected %06h actual %06h",
						$time, tinted_q[0], result_ch.color_out);
				end
				void'(tinted_q.pop_front());
			end
		end
	end

	task automatic send_beat(logic [23:0] color, logic signed [16:0] tint);
		while ($urandom_range(99) < src_idle_pct) begin
			color_ch.valid <= 1'b0;
			@(posedge clk);
		end
		color_ch.valid <= 1'b1;
		color_ch.color_in <= color;
		color_ch.tint_amount <= tint;
		do @(posedge clk); while (!color_ch.ready);
		tinted_q.insert(tinted_q.size(), tint_color(color, tint));
		beats_in++;
	endtask

	task automatic drain();
		color_ch.valid <= 1'b0;
		while (tinted_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [16:0] rand_tint();
		case ($urandom_range(9))
			0: return 17'(TINT_MAX);
			1: return 17'(TINT_MIN);
			2: return 17'sd0;
			3: return 17'($urandom_range(65535) - 32768);
			4: return 17'($urandom);
			default: return 17'($urandom_range(65536) - 32768);
		endcase
	endfunction

	initial begin
		stim_row_t rows[$];
		rows = '{
			'{24'h000000, 17'sd0, 1, 24'h000000},
			'{24'hffffff, 17'sd0, 1, 24'hffffff},
			'{24'h123456, 17'sd0, 1, 24'h123456},
			'{24'h123456, 17'(TINT_MAX), 1, 24'hffffff},
			'{24'h123456, 17'(TINT_MIN), 1, 24'h000000},
			'{24'hedcba9, 17'sh0ffff, 1, 24'hffffff},
			'{24'hedcba9, 17'sh10000, 1, 24'h000000},
			'{24'hedcba9, 17'sh10001, 1, 24'h000000},
			'{24'h808080, 17'sd16384, 0, 24'h0},
			'{24'h808080, -17'sd16384, 0, 24'h0},
			'{24'hff0000, 17'sd8192, 0, 24'h0},
			'{24'h00ff00, -17'sd8192, 0, 24'h0},
			'{24'h0000ff, 17'sd1, 0, 24'h0},
			'{24'hff00ff, -17'sd1, 0, 24'h0},
			'{24'hffff00, 17'sd20000, 0, 24'h0},
			'{24'h00ffff, -17'sd20000, 0, 24'h0},
			'{24'hff8000, 17'sd32767, 0, 24'h0},
			'{24'h10ff10, -17'sd32767, 0, 24'h0},
			'{24'h7f8081, 17'sd100, 0, 24'h0},
			'{24'h01fe80, -17'sd100, 0, 24'h0},
			'{24'haaaa00, 17'sd12345, 0, 24'h0}
		};
		color_ch.valid <= 1'b0;
		color_ch.color_in <= '0;
		color_ch.tint_amount <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].known && tint_color(rows[i].color, rows[i].tint) !== rows[i].color_exp) begin
				errors++;
				$display("%0t: table row %0d, expected %06h actual %06h", $time, i,
					rows[i].color_exp, tint_color(rows[i].color, rows[i].tint));
			end
			send_beat(rows[i].color, rows[i].tint);
		end
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 68 : 0;
			snk_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 19 : 0;
			if (ph == 2) hold_cycles = 200;
			for (int n = 0; n < 610; n++) begin
				logic [23:0] c;
				c = $urandom;
				if ($urandom_range(7) == 0) c = {3{c[7:0]}};
				send_beat(c, rand_tint());
			end
			drain();
		end
		repeat (LATENCY + 4) @(posedge clk);
		$display("tb: %0d beats in, %0d beats out, table plus three idle phases with hold-off",
			beats_in, beats_out);
		if (errors == 0 && tinted_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
